// ----- hw/rtl/circular_fifo_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// circular_fifo_queue_top_defines.svh
// Assertion macros used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH

// Check a same-cycle implication, skipped while reset is held.
`define CFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfq assertion failed");

// Check an implication in the next cycle, skipped while reset is held.
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfq assertion failed");

`endif

// ----- hw/rtl/cfq_pkg.sv -----
// ----------------------------------------------------------------------------
// cfq_pkg
// Types, codes and defaults for the circular FIFO queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 5;

  // Request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     is_empty;
    logic [1:0]               error_code;
  } out_t;

  // Per-cycle command broadcast to the cell chain
  typedef struct packed {
    logic                     shift;
    logic                     load;
    logic signed [DATA_W-1:0] word;
  } ctl_t;

endpackage

// ----- hw/rtl/cfq_cell.sv -----
// ----------------------------------------------------------------------------
// cfq_cell
// One storage cell of the queue chain; position IDX counted from the front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfq_cell #(
  parameter int IDX  = 0,
  parameter int CNTW = 5
) (
  input  logic                             clk,
  input  cfq_pkg::ctl_t                    ctl,
  input  logic [CNTW-1:0]                  count,
  input  logic signed [cfq_pkg::DATA_W-1:0] nbr_data,
  output logic signed [cfq_pkg::DATA_W-1:0] data
);

  logic signed [cfq_pkg::DATA_W-1:0] data_r;
  logic signed [cfq_pkg::DATA_W-1:0] data_nxt;

  // Advance toward the front on pop, take the word when this is the free slot
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = nbr_data;
    end else if (ctl.load && (count == CNTW'(IDX))) begin
      data_nxt = ctl.word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- hw/rtl/cfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfq_ctrl
// Request decode, entry count, back word and result strobe for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfq_ctrl #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEF,
  parameter int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  cfq_pkg::in_t                      req,
  output cfq_pkg::ctl_t                     ctl,
  output logic [CNTW-1:0]                   count,
  output logic signed [cfq_pkg::DATA_W-1:0] back,
  output logic [1:0]                        err,
  output logic                              strobe
);

  logic [CNTW-1:0]                   count_r, count_nxt;
  logic signed [cfq_pkg::DATA_W-1:0] back_r, back_nxt;
  logic [1:0]                        err_r, err_nxt;
  logic                              strobe_r;
  logic                              is_push, is_pop, is_clear;
  logic                              full, empty;

  assign is_push  = accept && (req.req_type == cfq_pkg::REQ_PUSH);
  assign is_pop   = accept && (req.req_type == cfq_pkg::REQ_POP);
  assign is_clear = accept && (req.req_type == cfq_pkg::REQ_CLEAR);
  assign full     = (count_r == CNTW'(DEPTH));
  assign empty    = (count_r == '0);

  // Drive the cell chain
  assign ctl.shift = is_pop && !empty;
  assign ctl.load  = is_push && !full;
  assign ctl.word  = req.push_value;

  // Update count, back word and error code
  always_comb begin
    count_nxt = count_r;
    back_nxt  = back_r;
    err_nxt   = err_r;
    if (accept) begin
      err_nxt = cfq_pkg::ERR_OK;
    end
    if (is_push) begin
      if (full) begin
        err_nxt = cfq_pkg::ERR_OVERFLOW;
      end else begin
        count_nxt = count_r + CNTW'(1);
        back_nxt  = req.push_value;
      end
    end else if (is_pop) begin
      if (empty) begin
        err_nxt = cfq_pkg::ERR_UNDERFLOW;
      end else begin
        count_nxt = count_r - CNTW'(1);
      end
    end else if (is_clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      err_r    <= cfq_pkg::ERR_OK;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      err_r    <= err_nxt;
      strobe_r <= accept;
    end
  end

  // Hold the last pushed word; only read while entries are stored
  always_ff @(posedge clk) begin
    back_r <= back_nxt;
  end

  assign count  = count_r;
  assign back   = back_r;
  assign err    = err_r;
  assign strobe = strobe_r;

endmodule

// ----- hw/rtl/circular_fifo_queue_top.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// FIFO queue of signed 32-bit words built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the transaction is taken at a clock edge
//   with start high and busy low. busy stays low, so a request can be issued
//   in every cycle: one transaction per clock.
//   Request kinds are push, pop, clear and query. Each transaction gives one
//   result, shown on out_item for exactly one cycle with out_valid high, in
//   the cycle right after the transaction.
//   The result reports the queue after the request: front and back words
//   (zero when empty), entry count, empty flag and an error code (underflow
//   on pop from empty, overflow on push to full; the queue is left as is).
//   Cell 0 holds the front word; a pop moves every cell one place toward the
//   front, and a push loads the cell at the count position.
//   The back word is kept in its own register in the control unit.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset (rst_n low, synchronous) empties the queue and drops the strobe;
//   cell contents are not cleared and are never shown while unused.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_fifo_queue_top_defines.svh"

module circular_fifo_queue_top #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cfq_pkg::in_t  in_item,
  output logic          out_valid,
  output cfq_pkg::out_t out_item
);

  localparam int CNTW = $clog2(DEPTH + 1);

  cfq_pkg::ctl_t                     ctl;
  logic [CNTW-1:0]                   cnt_w;
  logic signed [cfq_pkg::DATA_W-1:0] back_w;
  logic [1:0]                        err_w;
  logic                              accept;
  logic                              pop_on_empty;
  logic signed [cfq_pkg::DATA_W-1:0] cell_data [DEPTH];

  // Every cycle can take a transaction
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cfq_ctrl #(
    .DEPTH (DEPTH),
    .CNTW  (CNTW)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_item),
    .ctl    (ctl),
    .count  (cnt_w),
    .back   (back_w),
    .err    (err_w),
    .strobe (out_valid)
  );

  // Build the cell chain; the last cell feeds itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [cfq_pkg::DATA_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    cfq_cell #(
      .IDX  (i),
      .CNTW (CNTW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (cnt_w),
      .nbr_data (nbr),
      .data     (cell_data[i])
    );
  end

  // Assemble the result from the settled state
  always_comb begin
    out_item.is_empty    = (cnt_w == '0);
    out_item.front_value = out_item.is_empty ? '0 : cell_data[0];
    out_item.back_value  = out_item.is_empty ? '0 : back_w;
    out_item.entry_count = cfq_pkg::CNT_OUT_W'(cnt_w);
    out_item.error_code  = err_w;
  end

  // Pop taken while the queue is empty
  assign pop_on_empty = accept && (in_item.req_type == cfq_pkg::REQ_POP) && (cnt_w == '0);

  `CFQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_w <= CNTW'(DEPTH))
  `CFQ_ASSERT_IMP(a_empty_flag, clk, rst_n, out_valid, out_item.is_empty == (cnt_w == '0))
  `CFQ_ASSERT_NEXT(a_strobe, clk, rst_n, rst_n && accept, out_valid)
  `CFQ_ASSERT_NEXT(a_underflow, clk, rst_n, pop_on_empty, out_item.error_code == cfq_pkg::ERR_UNDERFLOW)

endmodule

// ----- sim/circular_fifo_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue_top_test
// Self-checking bench for the circular FIFO queue. Push, pop, clear and query
// requests are issued with random gaps. A local copy of the queue predicts
// each response, and every response strobe is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_fifo_queue_top_test;

  localparam int QDEPTH        = cfq_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 880;
  localparam int IDLE_LIMIT    = 200;
  localparam int DRAIN_CYCLES  = 4;

  logic          clk   = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  cfq_pkg::in_t  in_item = '0;
  logic          out_valid;
  cfq_pkg::out_t out_item;

  // Local copy of the queue
  logic signed [cfq_pkg::DATA_W-1:0] ring_words [QDEPTH];
  int front_idx;
  int back_idx;
  int word_count;

  cfq_pkg::out_t pending_responses [$];
  int   fail_count   = 0;
  int   idle_cycles  = 0;
  int   no_gap_left  = 0;

  circular_fifo_queue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Favor the corner words, otherwise any 32-bit pattern
  function automatic logic signed [cfq_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Draw the wait before the next transaction; now and then run back to back
  function automatic int draw_gap();
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) no_gap_left = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  // Apply one request to the local queue and return the response it gives
  function automatic cfq_pkg::out_t queue_response(cfq_pkg::in_t req);
    cfq_pkg::out_t rsp;
    rsp = '0;
    rsp.error_code = cfq_pkg::ERR_OK;
    case (req.req_type)
      cfq_pkg::REQ_PUSH: begin
        if (word_count >= QDEPTH) begin
          rsp.error_code = cfq_pkg::ERR_OVERFLOW;
        end else begin
          back_idx = (back_idx + 1) % QDEPTH;
          ring_words[back_idx] = req.push_value;
          word_count++;
        end
      end
      cfq_pkg::REQ_POP: begin
        if (word_count == 0) begin
          rsp.error_code = cfq_pkg::ERR_UNDERFLOW;
        end else begin
          front_idx = (front_idx + 1) % QDEPTH;
          word_count--;
        end
      end
      cfq_pkg::REQ_CLEAR: begin
        front_idx  = 0;
        back_idx   = QDEPTH - 1;
        word_count = 0;
      end
      default: ;
    endcase
    if (word_count == 0) begin
      rsp.is_empty = 1'b1;
    end else begin
      rsp.front_value = ring_words[front_idx];
      rsp.back_value  = ring_words[back_idx];
    end
    rsp.entry_count = cfq_pkg::CNT_OUT_W'(word_count);
    return rsp;
  endfunction

  // Issue one transaction after a random gap and record its response
  task automatic issue_request(cfq_pkg::in_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_item <= {cfq_pkg::REQ_QUERY, random_word()};
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    pending_responses.push_back(queue_response(req));
  endtask

  task automatic push_word(logic signed [cfq_pkg::DATA_W-1:0] word);
    issue_request({cfq_pkg::REQ_PUSH, word});
  endtask

  task automatic plain_request(logic [1:0] kind);
    issue_request({kind, random_word()});
  endtask

  // Query, pop and clear on an empty queue; pop must underflow
  task automatic check_empty_queue();
    plain_request(cfq_pkg::REQ_QUERY);
    plain_request(cfq_pkg::REQ_POP);
    plain_request(cfq_pkg::REQ_CLEAR);
  endtask

  // Fill to capacity, starting with corner words, then push once more to overflow
  task automatic check_fill_to_overflow();
    push_word(32'h8000_0000);
    push_word(32'h7FFF_FFFF);
    push_word('0);
    push_word('1);
    push_word(32'hAAAA_AAAA);
    push_word(32'h5555_5555);
    for (int i = 6; i < QDEPTH; i++) push_word(random_word());
    push_word(32'h1234_5678);
  endtask

  // Wrap the back index past the end of storage, then clear a non-empty queue
  task automatic check_wrap_and_clear();
    plain_request(cfq_pkg::REQ_POP);
    plain_request(cfq_pkg::REQ_POP);
    push_word(32'hDEAD_BEEF);
    plain_request(cfq_pkg::REQ_CLEAR);
  endtask

  // Segments that lean toward filling or draining, with some clears and queries
  task automatic run_random_traffic(int n_items);
    cfq_pkg::in_t req;
    int  issued;
    int  seg_left;
    int  push_pct;
    int  pick;
    issued   = 0;
    seg_left = 0;
    push_pct = 50;
    while (issued < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 48);
        push_pct = $urandom_range(0, 1) ? $urandom_range(60, 95) : $urandom_range(5, 40);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2)
        req.req_type = cfq_pkg::REQ_CLEAR;
      else if (pick < 7)
        req.req_type = cfq_pkg::REQ_QUERY;
      else if ($urandom_range(0, 99) < push_pct)
        req.req_type = cfq_pkg::REQ_PUSH;
      else
        req.req_type = cfq_pkg::REQ_POP;
      req.push_value = random_word();
      issue_request(req);
      issued++;
      seg_left--;
    end
  endtask

  // Compare each response strobe against the oldest prediction
  always @(posedge clk) begin : check_responses
    cfq_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_responses.size() == 0) begin
        $error("response with no transaction outstanding");
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        if (out_item.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, out_item.front_value);
          fail_count++;
        end
        if (out_item.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value, out_item.back_value);
          fail_count++;
        end
        if (out_item.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_item.entry_count);
          fail_count++;
        end
        if (out_item.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_item.is_empty);
          fail_count++;
        end
        if (out_item.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_item.error_code);
          fail_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("circular_fifo_queue_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    front_idx  = 0;
    back_idx   = QDEPTH - 1;
    word_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_empty_queue();
    check_fill_to_overflow();
    check_wrap_and_clear();
    run_random_traffic(RANDOM_ITEMS);

    // Drain outstanding responses, then watch for stray strobes
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) fail_count++;

    if (fail_count == 0)
      $display("circular_fifo_queue_top_test passed");
    else
      $display("circular_fifo_queue_top_test failed");
    $finish;
  end

endmodule
